@@ design/lockout_debounce_key_report_assert.svh @@
// Assertion macros used by the checker file.
`ifndef LOCKOUT_DEBOUNCE_KEY_REPORT_ASSERT_SVH
`define LOCKOUT_DEBOUNCE_KEY_REPORT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define LDKR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lockout_debounce_key_report: lbl failed");

// Next-cycle implication, disabled while in reset.
`define LDKR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lockout_debounce_key_report: lbl failed");

`endif

@@ design/ldkr_pkg.sv @@
`timescale 1ns / 1ps

package ldkr_pkg;

    localparam int KEY_COUNT   = 24;
    localparam int REPORT_BITS = 24;
    localparam int COUNT_W     = 5;
    localparam int TIME_W      = 32;
    localparam int DEB_W       = 16;
    localparam int KEY_IDX_W   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    localparam logic [KEY_IDX_W-1:0] LAST_KEY = KEY_IDX_W'(KEY_COUNT - 1);

    // APB register file
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_MAX_PRESSED = 1'b0;
    localparam logic REG_DEBOUNCE_MS = 1'b1;

    localparam logic [COUNT_W-1:0] MAX_PRESSED_RST = 5'd6;
    localparam logic [DEB_W-1:0]   DEBOUNCE_RST    = 16'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic out_free;
    } dp_status_t;

endpackage

@@ design/ldkr_cfg_regs.sv @@
`timescale 1ns / 1ps

module ldkr_cfg_regs
    import ldkr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [COUNT_W-1:0] max_pressed,
    output logic [DEB_W-1:0]   debounce_ms
);

    logic [COUNT_W-1:0] max_pressed_reg;
    logic [COUNT_W-1:0] max_pressed_next;
    logic [DEB_W-1:0]   debounce_reg;
    logic [DEB_W-1:0]   debounce_next;
    logic               wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        max_pressed_next = max_pressed_reg;
        debounce_next    = debounce_reg;
        if (wr_en) begin
            case (paddr[REG_SEL_BIT])
                REG_MAX_PRESSED: max_pressed_next = pwdata[COUNT_W-1:0];
                REG_DEBOUNCE_MS: debounce_next    = pwdata[DEB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[REG_SEL_BIT])
            REG_MAX_PRESSED: prdata = PDATA_W'(max_pressed_reg);
            REG_DEBOUNCE_MS: prdata = PDATA_W'(debounce_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_pressed_reg <= MAX_PRESSED_RST;
            debounce_reg    <= DEBOUNCE_RST;
        end else begin
            max_pressed_reg <= max_pressed_next;
            debounce_reg    <= debounce_next;
        end
    end

    assign max_pressed = max_pressed_reg;
    assign debounce_ms = debounce_reg;

endmodule

@@ design/ldkr_ctrl.sv @@
`timescale 1ns / 1ps

module ldkr_ctrl
    import ldkr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_WALK;
                end
            end
            ST_WALK: begin
                cmd.step = 1'b1;
                if (status.walk_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for the output register to drain
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/ldkr_datapath.sv @@
`timescale 1ns / 1ps

module ldkr_datapath
    import ldkr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    input  logic [TIME_W-1:0]      now_ms,
    input  logic [REPORT_BITS-1:0] raw_levels,
    input  logic [COUNT_W-1:0]     max_pressed,
    input  logic [DEB_W-1:0]       debounce_ms,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [REPORT_BITS-1:0] m_key_report,
    output logic [COUNT_W-1:0]     m_press_count
);

    // per-key debounce state
    logic [KEY_COUNT-1:0]   stable_reg;
    logic [TIME_W-1:0]      lock_reg [KEY_COUNT];

    // working registers of the current scan
    logic [TIME_W-1:0]      now_reg;
    logic [KEY_COUNT-1:0]   raw_reg;
    logic [KEY_IDX_W-1:0]   idx_reg;
    logic [REPORT_BITS-1:0] rpt_reg;
    logic [REPORT_BITS-1:0] rpt_next;
    logic [COUNT_W-1:0]     cnt_reg;
    logic [COUNT_W-1:0]     cnt_next;

    logic                   out_valid_reg;
    logic [REPORT_BITS-1:0] out_rpt_reg;
    logic [COUNT_W-1:0]     out_cnt_reg;

    logic [KEY_COUNT-1:0]   raw_ext;
    logic                   cur_raw;
    logic                   cur_stable;
    logic [TIME_W-1:0]      cur_lock;
    logic                   take_edge;
    logic                   new_level;
    logic                   in_report;
    logic                   pressed;
    logic [COUNT_W:0]       cnt_inc;
    logic                   limit_hit;
    logic [REPORT_BITS-1:0] key_mask;
    logic [TIME_W-1:0]      lock_new;

    // keys without a report bit read as released
    always_comb begin
        for (int i = 0; i < KEY_COUNT; i++) begin
            raw_ext[i] = (i < REPORT_BITS) ? raw_levels[i % REPORT_BITS] : 1'b1;
        end
    end

    always_comb begin
        for (int j = 0; j < REPORT_BITS; j++) begin
            key_mask[j] = (32'(idx_reg) == 32'(j));
        end
    end

    assign cur_raw    = raw_reg[idx_reg];
    assign cur_stable = stable_reg[idx_reg];
    assign cur_lock   = lock_reg[idx_reg];
    assign take_edge  = (cur_raw != cur_stable) && (now_reg >= cur_lock);
    assign new_level  = take_edge ? cur_raw : cur_stable;
    assign in_report  = (32'(idx_reg) < 32'(REPORT_BITS));
    assign pressed    = !new_level && in_report;
    assign cnt_inc    = {1'b0, cnt_reg} + (COUNT_W + 1)'(1);
    assign limit_hit  = pressed && (max_pressed != '0) && (cnt_inc >= {1'b0, max_pressed});
    assign lock_new   = now_reg + TIME_W'(debounce_ms);
    assign rpt_next   = pressed ? (rpt_reg & ~key_mask) : rpt_reg;
    assign cnt_next   = pressed ? cnt_inc[COUNT_W-1:0] : cnt_reg;

    assign status.walk_done = limit_hit || (idx_reg == LAST_KEY);
    assign status.out_free  = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg <= '1;
            for (int i = 0; i < KEY_COUNT; i++) begin
                lock_reg[i] <= '0;
            end
        end else if (cmd.step && take_edge) begin
            stable_reg[idx_reg] <= cur_raw;
            lock_reg[idx_reg]   <= lock_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            now_reg <= now_ms;
            raw_reg <= raw_ext;
            idx_reg <= '0;
            rpt_reg <= '1;
            cnt_reg <= '0;
        end else if (cmd.step) begin
            idx_reg <= idx_reg + KEY_IDX_W'(1);
            rpt_reg <= rpt_next;
            cnt_reg <= cnt_next;
        end
        if (cmd.load_out) begin
            out_rpt_reg <= rpt_reg;
            out_cnt_reg <= cnt_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_key_report  = out_rpt_reg;
    assign m_press_count = out_cnt_reg;

endmodule

@@ design/lockout_debounce_key_report.sv @@
// Key debounce with eager lockout and a pressed-key report. Each scan on the
// s_ channel (timestamp in ms, raw level per key, 0 = pressed) updates the
// debounced level of each key it visits, in index order, and returns one
// report on the m_ channel: all ones except cleared bits for pressed keys,
// plus their count. A scan is loaded, then visits the keys (all 24 with no
// limit, fewer when max_pressed stops the walk), then hands the report to
// the output register. The walk is paced by the single lockout compare and
// add unit, shared across keys and used once per cycle. A new scan is taken
// once the previous report sits in the output register, so a stalled m_
// channel delays the next scan. max_pressed (0x0) and debounce_ms (0x4) are
// to be written over APB only while no scan is in flight; the block itself
// does not enforce this. Lockout state resets to zero with no clearing pass.
`timescale 1ns / 1ps

module lockout_debounce_key_report
    import ldkr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [TIME_W-1:0]      s_now_ms,
    input  logic [REPORT_BITS-1:0] s_raw_levels,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [REPORT_BITS-1:0] m_key_report,
    output logic [COUNT_W-1:0]     m_press_count,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    logic [COUNT_W-1:0] max_pressed;
    logic [DEB_W-1:0]   debounce_ms;
    dp_cmd_t            cmd;
    dp_status_t         status;

    ldkr_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .max_pressed (max_pressed),
        .debounce_ms (debounce_ms)
    );

    ldkr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ldkr_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .now_ms        (s_now_ms),
        .raw_levels    (s_raw_levels),
        .max_pressed   (max_pressed),
        .debounce_ms   (debounce_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_key_report  (m_key_report),
        .m_press_count (m_press_count)
    );

endmodule

@@ design/ldkr_checker.sv @@
`timescale 1ns / 1ps
`include "lockout_debounce_key_report_assert.svh"

module ldkr_checker
    import ldkr_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [REPORT_BITS-1:0] m_key_report,
    input logic [COUNT_W-1:0]     m_press_count
);

    // held report must not change until transfer
    `LDKR_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_key_report) && $stable(m_press_count))

    // count agrees with the cleared bits of the report
    `LDKR_ASSERT_IMP(a_count_match, aclk, aresetn, m_valid, $countones(~m_key_report) == 32'(m_press_count))

    `LDKR_ASSERT_IMP(a_count_range, aclk, aresetn, m_valid, m_press_count <= COUNT_W'(REPORT_BITS))

    // one scan at a time: no second transfer right after the first
    `LDKR_ASSERT_NXT(a_one_scan, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

bind lockout_debounce_key_report ldkr_checker u_ldkr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_key_report  (m_key_report),
    .m_press_count (m_press_count)
);
